[rtl/rle_encoder_literal_runs_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the run-length encoder
// Clocked concurrent checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef RLE_ENCODER_LITERAL_RUNS_ASSERT_SVH
`define RLE_ENCODER_LITERAL_RUNS_ASSERT_SVH

// property checked at every rising edge of clk
`define RLELR_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("rle encoder check failed");

// antecedent in this cycle, consequent in the next one
`define RLELR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rle encoder check failed");

`endif

[rtl/rlelr_pkg.sv]
// ----------------------------------------------------------------------------
// rlelr_pkg
// Shared constants and types of the run-length encoder.
// ----------------------------------------------------------------------------
package rlelr_pkg;

	localparam int MAX_LITERAL = 32;
	localparam int MAX_RUN     = 255;
	localparam int LIT_CNT_W   = $clog2(MAX_LITERAL + 1);

	typedef enum logic [1:0] {
		TK_RUN  = 2'd0,
		TK_HDR  = 2'd1,
		TK_DATA = 2'd2
	} token_kind_t;

	// controls from the sequencer to the literal chain
	typedef struct packed {
		logic       push;
		logic       pop;
		logic       clear;
		logic [7:0] data;
	} chain_ctl_t;

endpackage

[rtl/rlelr_cell.sv]
// ----------------------------------------------------------------------------
// rlelr_cell
// One byte slot of the literal chain: loads a pushed byte or takes its
// right neighbor's byte when the chain shifts toward the head.
// ----------------------------------------------------------------------------
module rlelr_cell (
	input  logic       clk,
	input  logic       load,
	input  logic       shift,
	input  logic [7:0] load_data,
	input  logic [7:0] next_data,
	output logic [7:0] data
);

	logic [7:0] data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end else if (shift) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

[rtl/rlelr_chain.sv]
// ----------------------------------------------------------------------------
// rlelr_chain
// Row of byte cells buffering lone bytes. Pushes land at the fill point,
// pops shift every cell one place toward the head.
// ----------------------------------------------------------------------------
module rlelr_chain (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rlelr_pkg::chain_ctl_t           ctl,
	output logic [7:0]                      head,
	output logic [rlelr_pkg::LIT_CNT_W-1:0] count
);

	logic [7:0]                      cell_data [rlelr_pkg::MAX_LITERAL];
	logic [rlelr_pkg::LIT_CNT_W-1:0] count_q;

	for (genvar i = 0; i < rlelr_pkg::MAX_LITERAL; i++) begin : g_cell
		logic [7:0] next_data;

		if (i == rlelr_pkg::MAX_LITERAL - 1) begin : g_tail
			assign next_data = 8'h00;
		end else begin : g_body
			assign next_data = cell_data[i+1];
		end

		rlelr_cell u_cell (
			.clk       (clk),
			.load      (ctl.push && (count_q == rlelr_pkg::LIT_CNT_W'(i))),
			.shift     (ctl.pop),
			.load_data (ctl.data),
			.next_data (next_data),
			.data      (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clear) begin
			count_q <= '0;
		end else if (ctl.push) begin
			count_q <= count_q + 1'b1;
		end else if (ctl.pop) begin
			count_q <= count_q - 1'b1;
		end
	end

	assign head  = cell_data[0];
	assign count = count_q;

endmodule

[rtl/rle_encoder_literal_runs.sv]
// ----------------------------------------------------------------------------
// rle_encoder_literal_runs
// Run-length encoder with literal bursts, one byte per request.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with in_byte and last_byte; last_byte ends
// a stream and the next byte starts a fresh one.
// Output channel: out_valid/out_stall with token_kind, run_count, out_byte,
// last_of_burst (final token of one input byte) and end_of_output (final
// token of the stream). Tokens leave through one output register.
// A byte that yields no token is taken without a stall, back to back.
// A byte that yields tokens holds in_stall until its tokens are loaded:
// a run token, or a literal burst as a header and then its data bytes,
// with a push step (S_PUSH2) before the closing group of a last byte.
// The sequencer loads one token a cycle into the output register while
// the receiver does not stall. A last byte whose only tokens are in the
// closing group passes the push step before its first token is loaded.
// When the receiver stalls, the output register holds and the sequencer
// waits; a new byte may still be taken while a token waits, as long as the
// previous byte's tokens are all loaded.
// Reset clears the pending run, the literal fill count and the output
// register; buffered literal bytes are dropped.
// ----------------------------------------------------------------------------
module rle_encoder_literal_runs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        in_byte,
	input  logic              last_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        token_kind,
	output logic signed [8:0] run_count,
	output logic [7:0]        out_byte,
	output logic              last_of_burst,
	output logic              end_of_output
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_OP,
		S_PUSH2,
		S_DATA
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_RUN,
		OP_FLUSH
	} op_t;

	state_t state_q;
	logic   phase_q;
	logic   last_q;

	logic [7:0] cur_q;
	logic [7:0] run_q;
	logic       have_q;

	op_t        op1_q, op2_q;
	logic [7:0] r1_cnt_q, r1_byte_q;
	logic [7:0] r2_cnt_q, r2_byte_q;
	logic       push2_q;

	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic signed [8:0] count_q;
	logic [7:0]        obyte_q;
	logic              lob_q;
	logic              eoo_q;

	logic                            accept;
	logic                            out_free;
	logic                            tok_load;
	logic [7:0]                      lit_head;
	logic [rlelr_pkg::LIT_CNT_W-1:0] lit_count;
	rlelr_pkg::chain_ctl_t           chain_ctl;

	// decode of the byte being taken
	logic       same;
	logic       push1;
	op_t        op1_n, op2_n;
	logic [7:0] r1_cnt_n, r1_byte_n;
	logic [7:0] new_cur, new_run;
	logic       push2_n;

	op_t        op_sel;
	logic [7:0] cnt_sel, byte_sel;
	logic       final_grp;
	logic       lit_one;
	state_t     after_state;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		same      = (in_byte == cur_q) && (run_q < 8'(rlelr_pkg::MAX_RUN));
		push1     = 1'b0;
		op1_n     = OP_NONE;
		r1_cnt_n  = run_q;
		r1_byte_n = cur_q;
		new_cur   = in_byte;
		new_run   = 8'd1;
		if (have_q) begin
			if (same) begin
				new_cur = cur_q;
				new_run = run_q + 8'd1;
				// run just became a pair: send the buffered lone bytes
				if (run_q == 8'd1 && lit_count != '0) begin
					op1_n = OP_FLUSH;
				end
			end else if (run_q >= 8'd2) begin
				op1_n = OP_RUN;
			end else begin
				push1 = 1'b1;
				if (lit_count == rlelr_pkg::LIT_CNT_W'(rlelr_pkg::MAX_LITERAL - 1)) begin
					op1_n = OP_FLUSH;
				end
			end
		end
		// closing group of a stream
		push2_n = (new_run < 8'd2);
		op2_n   = push2_n ? OP_FLUSH : OP_RUN;
	end

	assign op_sel      = phase_q ? op2_q : op1_q;
	assign cnt_sel     = phase_q ? r2_cnt_q : r1_cnt_q;
	assign byte_sel    = phase_q ? r2_byte_q : r1_byte_q;
	assign final_grp   = phase_q || !last_q;
	assign lit_one     = (lit_count == rlelr_pkg::LIT_CNT_W'(1));
	assign after_state = (!phase_q && last_q) ? S_PUSH2 : S_IDLE;
	assign tok_load    = out_free
		&& (((state_q == S_OP) && (op_sel != OP_NONE)) || (state_q == S_DATA));

	always_comb begin
		chain_ctl = '0;
		unique case (state_q)
			S_IDLE: begin
				chain_ctl.push = accept && push1;
				chain_ctl.data = cur_q;
			end
			S_PUSH2: begin
				chain_ctl.push = push2_q;
				chain_ctl.data = r2_byte_q;
			end
			S_OP: begin
				chain_ctl.clear = out_free && (op_sel == OP_FLUSH) && lit_one;
			end
			S_DATA: begin
				chain_ctl.pop = out_free;
			end
			default: begin
				chain_ctl = '0;
			end
		endcase
	end

	rlelr_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (chain_ctl),
		.head   (lit_head),
		.count  (lit_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= 1'b0;
			last_q      <= 1'b0;
			cur_q       <= 8'd0;
			run_q       <= 8'd0;
			have_q      <= 1'b0;
			op1_q       <= OP_NONE;
			op2_q       <= OP_NONE;
			r1_cnt_q    <= 8'd0;
			r1_byte_q   <= 8'd0;
			r2_cnt_q    <= 8'd0;
			r2_byte_q   <= 8'd0;
			push2_q     <= 1'b0;
			out_valid_q <= 1'b0;
			kind_q      <= rlelr_pkg::TK_RUN;
			count_q     <= '0;
			obyte_q     <= 8'd0;
			lob_q       <= 1'b0;
			eoo_q       <= 1'b0;
		end else begin
			if (tok_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op1_q     <= op1_n;
						r1_cnt_q  <= r1_cnt_n;
						r1_byte_q <= r1_byte_n;
						op2_q     <= op2_n;
						r2_cnt_q  <= new_run;
						r2_byte_q <= new_cur;
						push2_q   <= push2_n;
						last_q    <= last_byte;
						phase_q   <= 1'b0;
						if (last_byte) begin
							cur_q  <= 8'd0;
							run_q  <= 8'd0;
							have_q <= 1'b0;
						end else begin
							cur_q  <= new_cur;
							run_q  <= new_run;
							have_q <= 1'b1;
						end
						if (op1_n != OP_NONE) begin
							state_q <= S_OP;
						end else if (last_byte) begin
							state_q <= S_PUSH2;
						end
					end
				end
				S_PUSH2: begin
					phase_q <= 1'b1;
					state_q <= S_OP;
				end
				S_OP: begin
					unique case (op_sel)
						OP_RUN: begin
							if (out_free) begin
								kind_q      <= rlelr_pkg::TK_RUN;
								count_q     <= $signed({1'b0, cnt_sel});
								obyte_q     <= byte_sel;
								lob_q       <= final_grp;
								eoo_q       <= final_grp && last_q;
								state_q     <= after_state;
							end
						end
						OP_FLUSH: begin
							if (out_free) begin
								if (lit_one) begin
									// a single lone byte goes out as a run of one
									kind_q  <= rlelr_pkg::TK_RUN;
									count_q <= 9'sd1;
									obyte_q <= lit_head;
									lob_q   <= final_grp;
									eoo_q   <= final_grp && last_q;
									state_q <= after_state;
								end else begin
									kind_q  <= rlelr_pkg::TK_HDR;
									count_q <= $signed(9'd0 - 9'(lit_count));
									obyte_q <= 8'd0;
									lob_q   <= 1'b0;
									eoo_q   <= 1'b0;
									state_q <= S_DATA;
								end
							end
						end
						default: begin
							state_q <= after_state;
						end
					endcase
				end
				S_DATA: begin
					if (out_free) begin
						kind_q      <= rlelr_pkg::TK_DATA;
						count_q     <= '0;
						obyte_q     <= lit_head;
						lob_q       <= lit_one && final_grp;
						eoo_q       <= lit_one && final_grp && last_q;
						if (lit_one) begin
							state_q <= after_state;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign token_kind    = kind_q;
	assign run_count     = count_q;
	assign out_byte      = obyte_q;
	assign last_of_burst = lob_q;
	assign end_of_output = eoo_q;

endmodule

[rtl/rlelr_monitor.sv]
// ----------------------------------------------------------------------------
// rlelr_monitor
// Port-level checks of the run-length encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "rle_encoder_literal_runs_assert.svh"

module rlelr_monitor (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [7:0]        in_byte,
	input logic              last_byte,
	input logic              out_valid,
	input logic              out_stall,
	input logic [1:0]        token_kind,
	input logic signed [8:0] run_count,
	input logic [7:0]        out_byte,
	input logic              last_of_burst,
	input logic              end_of_output
);

	logic hdr_tok;
	logic data_tok;

	assign hdr_tok  = out_valid && (token_kind == rlelr_pkg::TK_HDR);
	assign data_tok = out_valid && (token_kind == rlelr_pkg::TK_DATA);

	// a waiting token stays offered
	`RLELR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	// stream end only on the closing token of a byte
	`RLELR_ASSERT(a_eoo_lob, !out_valid || !end_of_output || last_of_burst)
	// a header is always followed by data, carries a negative count and no byte
	`RLELR_ASSERT(a_hdr_form, !hdr_tok || (!last_of_burst && run_count[8] && out_byte == 8'd0))
	// literal data carries no count
	`RLELR_ASSERT(a_data_form, !data_tok || (run_count == 9'sd0))

endmodule

bind rle_encoder_literal_runs rlelr_monitor u_monitor (.*);
